/* rtl/core/adaptive_threshold_serpentine_unit_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ADAPTIVE_THRESHOLD_SERPENTINE_UNIT_MACROS_SVH
`define ADAPTIVE_THRESHOLD_SERPENTINE_UNIT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ATSU_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ATSU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ATSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/atsu_pkg.sv */
package atsu_pkg;

    localparam int LINE_WIDTH_W    = 13;
    localparam int PERCENT_W       = 7;
    localparam int PIXEL_W         = 8;
    localparam int COLUMN_W        = 12;
    localparam int SUM_W           = 24;
    localparam int WIN_SHIFT       = 3;
    localparam int WIN_W           = LINE_WIDTH_W - WIN_SHIFT;
    localparam int DEN_W           = WIN_W + PERCENT_W;
    localparam int APB_DATA_W      = 32;
    localparam int CFG_ADDR_W      = 3;
    localparam int REG_SEL_BIT     = 2;

    localparam int INIT_LEVEL      = 127;
    localparam int PERCENT_SCALE   = 100;
    localparam int PERCENT_MAX     = 99;
    localparam int PERCENT_DEFAULT = 15;
    localparam int WIDTH_DEFAULT   = 640;
    localparam int WIDTH_MIN       = 8;

    // register select, taken from paddr[REG_SEL_BIT]
    localparam logic REG_LINE_WIDTH = 1'b0;
    localparam logic REG_PERCENT    = 1'b1;

    typedef enum logic [2:0] {
        DV_IDLE,
        DV_LAUNCH_DECAY,
        DV_WAIT_DECAY,
        DV_LAUNCH_FACTOR,
        DV_WAIT_FACTOR
    } t_drv_state;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SUM,
        CS_THR
    } t_core_state;

    typedef struct packed {
        logic                    busy;
        logic [LINE_WIDTH_W-1:0] width;
        logic [SUM_W-1:0]        init;
    } t_cfg_status;

    typedef struct packed {
        logic                white;
        logic [COLUMN_W-1:0] column;
    } t_result;

    // window size after reset, for a store of max_width columns
    function automatic int default_window(input int max_width);
        int w;
        begin
            w = (WIDTH_DEFAULT < max_width) ? WIDTH_DEFAULT : max_width;
            return w >> WIN_SHIFT;
        end
    endfunction

endpackage

/* rtl/core/atsu_div.sv */
`include "adaptive_threshold_serpentine_unit_macros.svh"

module atsu_div #(
    parameter int NW = 16,
    parameter int DW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CntW = $clog2(NW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CntW-1:0] r_cnt;
    logic [NW-1:0]   r_num;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_den;

    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            fits;

    // restoring division, one quotient bit per cycle; quotient shifts into r_num
    always_comb begin
        trial = {r_rem, r_num[NW-1]};
        fits  = (trial >= {1'b0, r_den});
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CntW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CntW'(1);
            if (r_cnt == CntW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], fits};
            r_rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_num;

    `ATSU_ASSERT_IMPLY(a_div_done_idle, i_clk, i_rst_n, o_done, !o_busy, "done while busy")
    `ATSU_ASSERT_IMPLY(a_div_rem_bound, i_clk, i_rst_n, r_busy, r_rem < r_den, "remainder overrun")
    `ATSU_ASSERT_NEXT(a_div_start_busy, i_clk, i_rst_n, i_start, o_busy && !o_done, "start lost")

endmodule

/* rtl/core/atsu_cfg.sv */
`include "adaptive_threshold_serpentine_unit_macros.svh"

module atsu_cfg #(
    parameter int MAX_WIDTH = 4096,
    parameter int FRAC_BITS = 9
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [atsu_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [atsu_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [atsu_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output atsu_pkg::t_cfg_status                o_status,
    output logic [FRAC_BITS:0]                   o_decay,
    output logic [FRAC_BITS:0]                   o_factor
);
    import atsu_pkg::*;

    localparam int FW        = FRAC_BITS + 1;
    localparam int NW        = FRAC_BITS + PERCENT_W;
    localparam int One       = 1 << FRAC_BITS;
    localparam int DefWin    = default_window(MAX_WIDTH);
    localparam int DefDecay  = One - One / DefWin;
    localparam int DefFactor = One * (PERCENT_SCALE - PERCENT_DEFAULT)
                               / (PERCENT_SCALE * DefWin);

    t_drv_state              r_state;
    t_drv_state              n_state;
    logic [LINE_WIDTH_W-1:0] r_line_width;
    logic [PERCENT_W-1:0]    r_percent;
    logic [FW-1:0]           r_decay;
    logic [FW-1:0]           r_factor;

    logic                    wr;
    logic [LINE_WIDTH_W-1:0] eff_w;
    logic [WIN_W-1:0]        win;
    logic [PERCENT_W-1:0]    pct_sat;
    logic                    div_start;
    logic                    sel_factor;
    logic                    cap_decay;
    logic                    cap_factor;
    logic [NW-1:0]           div_num;
    logic [DEN_W-1:0]        div_den;
    logic                    div_busy;
    logic                    div_done;
    logic [NW-1:0]           div_quo;

    assign wr     = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        eff_w = r_line_width;
        if (r_line_width < LINE_WIDTH_W'(WIDTH_MIN)) begin
            eff_w = LINE_WIDTH_W'(WIDTH_MIN);
        end else if (32'(r_line_width) > MAX_WIDTH) begin
            eff_w = LINE_WIDTH_W'(MAX_WIDTH);
        end
    end

    assign win     = eff_w[LINE_WIDTH_W-1:WIN_SHIFT];
    assign pct_sat = (r_percent > PERCENT_W'(PERCENT_MAX)) ? PERCENT_W'(PERCENT_MAX) : r_percent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_W'(WIDTH_DEFAULT);
            r_percent    <= PERCENT_W'(PERCENT_DEFAULT);
        end else if (wr) begin
            case (paddr[REG_SEL_BIT])
                REG_LINE_WIDTH: r_line_width <= pwdata[LINE_WIDTH_W-1:0];
                REG_PERCENT:    r_percent    <= pwdata[PERCENT_W-1:0];
                default:        r_percent    <= r_percent;
            endcase
        end
    end

    always_comb begin
        case (paddr[REG_SEL_BIT])
            REG_LINE_WIDTH: prdata = APB_DATA_W'(r_line_width);
            REG_PERCENT:    prdata = APB_DATA_W'(r_percent);
            default:        prdata = '0;
        endcase
    end

    // decay and factor are re-derived after every write; a write mid-way restarts the derivation
    always_comb begin
        case (r_state)
            DV_IDLE:          n_state = DV_IDLE;
            DV_LAUNCH_DECAY:  n_state = DV_WAIT_DECAY;
            DV_WAIT_DECAY:    n_state = div_done ? DV_LAUNCH_FACTOR : DV_WAIT_DECAY;
            DV_LAUNCH_FACTOR: n_state = DV_WAIT_FACTOR;
            DV_WAIT_FACTOR:   n_state = div_done ? DV_IDLE : DV_WAIT_FACTOR;
            default:          n_state = DV_IDLE;
        endcase
        if (wr) begin
            n_state = DV_LAUNCH_DECAY;
        end
    end

    always_comb begin
        div_start  = (r_state == DV_LAUNCH_DECAY) || (r_state == DV_LAUNCH_FACTOR);
        sel_factor = (r_state == DV_LAUNCH_FACTOR);
        cap_decay  = (r_state == DV_WAIT_DECAY) && div_done;
        cap_factor = (r_state == DV_WAIT_FACTOR) && div_done;
    end

    always_comb begin
        if (sel_factor) begin
            div_num = NW'(PERCENT_W'(PERCENT_SCALE) - pct_sat) << FRAC_BITS;
            div_den = DEN_W'(win) * DEN_W'(PERCENT_SCALE);
        end else begin
            div_num = NW'(One);
            div_den = DEN_W'(win);
        end
    end

    atsu_div #(
        .NW (NW),
        .DW (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= DV_IDLE;
            r_decay  <= FW'(DefDecay);
            r_factor <= FW'(DefFactor);
        end else begin
            r_state <= n_state;
            if (cap_decay) begin
                r_decay <= FW'(One) - div_quo[FW-1:0];
            end
            if (cap_factor) begin
                r_factor <= div_quo[FW-1:0];
            end
        end
    end

    always_comb begin
        // no pixel is taken at the edge of a register write either
        o_status.busy  = (r_state != DV_IDLE) || wr;
        o_status.width = eff_w;
        // 127 * s
        o_status.init  = SUM_W'(win) * SUM_W'(INIT_LEVEL);
    end

    assign o_decay  = r_decay;
    assign o_factor = r_factor;

    `ATSU_ASSERT_ALWAYS(a_cfg_decay_bound, i_clk, i_rst_n, r_decay <= FW'(One), "decay above one")
    `ATSU_ASSERT_ALWAYS(a_cfg_factor_bound, i_clk, i_rst_n, r_factor <= FW'(One), "factor above one")
    `ATSU_ASSERT_IMPLY(a_cfg_idle_quiet, i_clk, i_rst_n, r_state == DV_IDLE, !div_busy, "divider left running")

endmodule

/* rtl/core/atsu_core.sv */
`include "adaptive_threshold_serpentine_unit_macros.svh"

module atsu_core #(
    parameter int MAX_WIDTH = 4096,
    parameter int FRAC_BITS = 9
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [atsu_pkg::PIXEL_W-1:0]   i_pixel,
    input  logic                           i_frame_start,
    input  atsu_pkg::t_cfg_status          i_cfg,
    input  logic [FRAC_BITS:0]             i_decay,
    input  logic [FRAC_BITS:0]             i_factor,
    input  logic                           i_res_free,
    output logic                           o_res_load,
    output atsu_pkg::t_result              o_res
);
    import atsu_pkg::*;

    localparam int FW      = FRAC_BITS + 1;
    localparam int AW      = $clog2(MAX_WIDTH);
    localparam int ProdW   = SUM_W + FW;
    localparam int ThrW    = SUM_W + 1;
    localparam int DefInit = INIT_LEVEL * default_window(MAX_WIDTH);

    t_core_state             r_state;
    t_core_state             n_state;

    logic [LINE_WIDTH_W-1:0] r_cc;
    logic                    r_dir;
    logic                    r_first;
    logic [SUM_W-1:0]        r_rs;

    logic [PIXEL_W-1:0]      r_pixel;
    logic [LINE_WIDTH_W-1:0] r_x;
    logic                    r_first_item;
    logic [ProdW-1:0]        r_prod;
    logic [SUM_W-1:0]        r_rdata;
    logic [SUM_W-1:0]        r_h;
    logic [SUM_W-1:0]        r_mem [MAX_WIDTH];

    logic                    accept;
    logic                    mem_we;
    logic [LINE_WIDTH_W-1:0] w;
    logic [LINE_WIDTH_W-1:0] cc_base;
    logic [LINE_WIDTH_W-1:0] cc_eff;
    logic [LINE_WIDTH_W-1:0] cc_inc;
    logic                    dir;
    logic                    first;
    logic                    wrap;
    logic [LINE_WIDTH_W-1:0] x;
    logic [SUM_W-1:0]        rs_base;
    logic [ProdW-1:0]        prod;
    logic [SUM_W-1:0]        g;
    logic [SUM_W-1:0]        above;
    logic [SUM_W:0]          hsum;
    logic [ProdW-1:0]        tprod;
    logic [ThrW-1:0]         thr;

    assign w      = i_cfg.width;
    assign accept = i_in_valid && !o_in_stall;

    // column bookkeeping and decayed sum for the item being taken
    always_comb begin
        cc_base = i_frame_start ? '0 : r_cc;
        dir     = i_frame_start ? 1'b0 : r_dir;
        first   = i_frame_start ? 1'b1 : r_first;
        cc_eff  = (cc_base >= w) ? '0 : cc_base;
        x       = dir ? (w - LINE_WIDTH_W'(1) - cc_eff) : cc_eff;
        cc_inc  = cc_eff + LINE_WIDTH_W'(1);
        wrap    = (cc_inc >= w);
        rs_base = i_frame_start ? i_cfg.init : r_rs;
        prod    = ProdW'(rs_base) * ProdW'(i_decay);
    end

    always_comb begin
        g     = SUM_W'(r_prod >> FRAC_BITS) + SUM_W'(r_pixel);
        above = r_first_item ? i_cfg.init : r_rdata;
        hsum  = {1'b0, g} + {1'b0, above};
        tprod = ProdW'(r_h) * ProdW'(i_factor);
        thr   = ThrW'(tprod >> FRAC_BITS);
    end

    always_comb begin
        case (r_state)
            CS_IDLE: n_state = accept ? CS_SUM : CS_IDLE;
            CS_SUM:  n_state = CS_THR;
            CS_THR:  n_state = i_res_free ? CS_IDLE : CS_THR;
            default: n_state = CS_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != CS_IDLE) || i_cfg.busy;
        mem_we     = (r_state == CS_SUM);
        o_res_load = (r_state == CS_THR) && i_res_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_cc    <= '0;
            r_dir   <= 1'b0;
            r_first <= 1'b1;
            r_rs    <= SUM_W'(DefInit);
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_cc    <= wrap ? '0 : cc_inc;
                r_dir   <= wrap ? !dir : dir;
                r_first <= wrap ? 1'b0 : first;
            end
            if (mem_we) begin
                r_rs <= g;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pixel      <= i_pixel;
            r_x          <= x;
            r_first_item <= first;
            r_prod       <= prod;
        end
        if (mem_we) begin
            r_h <= hsum[SUM_W:1];
        end
    end

    // The write of one pixel (SUM state) lands before the next read is issued (on the next take,
    // after the THR state), so the row turn-around (same column twice) needs no bypass.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[AW'(r_x)] <= g;
        end
        if (accept) begin
            r_rdata <= r_mem[AW'(x)];
        end
    end

    always_comb begin
        o_res.white  = (ThrW'(r_pixel) >= thr);
        o_res.column = r_x[COLUMN_W-1:0];
    end

    `ATSU_ASSERT_NEXT(a_core_cc_range, i_clk, i_rst_n, accept, r_cc < $past(w), "column count overran row")
    `ATSU_ASSERT_NEXT(a_core_x_range, i_clk, i_rst_n, accept, r_x < $past(w), "column outside row")
    `ATSU_ASSERT_NEXT(a_core_frame_restart, i_clk, i_rst_n, accept && i_frame_start, r_cc == LINE_WIDTH_W'(1) && !r_dir, "frame start not applied")

endmodule

/* rtl/core/adaptive_threshold_serpentine_unit.sv */
// Adaptive threshold binariser: takes 8-bit gray pixels in serpentine order (even rows left to
// right, odd rows right to left) and returns one white/black decision plus its column per pixel,
// comparing each pixel with a decaying running sum averaged against the sum stored for the same
// column in the row above. Each pixel passes through the take, the read-modify-write of the row
// store and the threshold multiply, waiting in the last step while the output side stalls; no new
// pixel is taken before that result is loaded, but a result waiting in the output register does
// not stop the next pixel from being taken. The row store is not cleared: the first row of
// a frame uses 127*s in its place. After each register write the input is stalled while a
// bit-serial divider re-derives the decay ratio and scale factor.
`include "adaptive_threshold_serpentine_unit_macros.svh"

module adaptive_threshold_serpentine_unit #(
    parameter int MAX_WIDTH = 4096,
    parameter int FRAC_BITS = 9
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [atsu_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [atsu_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [atsu_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [atsu_pkg::PIXEL_W-1:0]      i_pixel,
    input  logic                              i_frame_start,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_white,
    output logic [atsu_pkg::COLUMN_W-1:0]     o_column
);
    import atsu_pkg::*;

    t_cfg_status         cfg_status;
    logic [FRAC_BITS:0]  decay;
    logic [FRAC_BITS:0]  factor;
    logic                res_free;
    logic                res_load;
    t_result             res;

    logic                r_out_valid;
    t_result             r_res;

    atsu_cfg #(
        .MAX_WIDTH (MAX_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_status (cfg_status),
        .o_decay  (decay),
        .o_factor (factor)
    );

    atsu_core #(
        .MAX_WIDTH (MAX_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .i_cfg         (cfg_status),
        .i_decay       (decay),
        .i_factor      (factor),
        .i_res_free    (res_free),
        .o_res_load    (res_load),
        .o_res         (res)
    );

    // output register is free when empty or being taken this cycle
    assign res_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_res <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_white     = r_res.white;
    assign o_column    = r_res.column;

    `ATSU_ASSERT_IMPLY(a_top_load_free, i_clk, i_rst_n, res_load, !r_out_valid || !i_out_stall, "result overwrote pending transaction")
    `ATSU_ASSERT_NEXT(a_top_load_shows, i_clk, i_rst_n, res_load, o_out_valid, "loaded result not presented")
    `ATSU_ASSERT_IMPLY(a_top_no_take_deriving, i_clk, i_rst_n, i_in_valid && !o_in_stall, !cfg_status.busy, "pixel taken during derivation")

endmodule

/* test/binarise_checker.sv */
`timescale 1ns / 100ps

module binarise_checker
    import atsu_pkg::*;
#(
    parameter int MAX_COLS = 4096,
    parameter int FRAC     = 9
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [PIXEL_W-1:0]      pixel,
    input  logic                    frame_start,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic                    white,
    input  logic [COLUMN_W-1:0]     column,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic                    pready,
    input  logic [CFG_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output int                      mismatch_count,
    output int                      pixels_in_flight
);

    logic [LINE_WIDTH_W-1:0] width_reg;
    logic [PERCENT_W-1:0]    percent_reg;
    logic [9:0]              decay;
    logic [9:0]              factor;
    logic [SUM_W-1:0]        run_sum;
    bit   [SUM_W-1:0]        col_sums [MAX_COLS];
    int                      col_pos;
    bit                      backwards;
    bit                      top_row;
    t_result                 expected_pixels [$];

    function automatic int eff_width(input logic [LINE_WIDTH_W-1:0] w);
        if (w < WIDTH_MIN) return WIDTH_MIN;
        if (w > MAX_COLS) return MAX_COLS;
        return int'(w);
    endfunction

    function automatic void rederive();
        int s;
        int t;
        s = eff_width(width_reg) >> WIN_SHIFT;
        t = (percent_reg > PERCENT_MAX) ? PERCENT_MAX : int'(percent_reg);
        decay  = 10'((1 << FRAC) - (1 << FRAC) / s);
        factor = 10'(((1 << FRAC) * (PERCENT_SCALE - t)) / (PERCENT_SCALE * s));
    endfunction

    // one pixel through the decaying sum and the row-above average
    function automatic t_result threshold_pixel(input logic [PIXEL_W-1:0] p, input logic fs);
        int               w;
        int               x;
        logic [SUM_W-1:0] init;
        logic [SUM_W-1:0] above;
        longint           g;
        longint           h;
        longint           thr;
        t_result          r;
        w    = eff_width(width_reg);
        init = SUM_W'(INIT_LEVEL * (w >> WIN_SHIFT));
        if (fs) begin
            run_sum   = init;
            col_pos   = 0;
            backwards = 1'b0;
            top_row   = 1'b1;
        end
        // width shrunk mid-row: restart the row, keep direction
        if (col_pos >= w) col_pos = 0;
        x = backwards ? (w - 1 - col_pos) : col_pos;
        g = ((longint'(run_sum) * longint'(decay)) >> FRAC) + longint'(p);
        run_sum = SUM_W'(g);
        above = top_row ? init : col_sums[x];
        col_sums[x] = run_sum;
        h   = (longint'(run_sum) + longint'(above)) >> 1;
        thr = (h * longint'(factor)) >> FRAC;
        r.white  = (longint'(p) < thr) ? 1'b0 : 1'b1;
        r.column = COLUMN_W'(x);
        col_pos++;
        if (col_pos >= w) begin
            col_pos   = 0;
            backwards = !backwards;
            top_row   = 1'b0;
        end
        return r;
    endfunction

    always @(posedge clk) begin
        t_result want;
        if (!rst_n) begin
            width_reg   = LINE_WIDTH_W'(WIDTH_DEFAULT);
            percent_reg = PERCENT_W'(PERCENT_DEFAULT);
            rederive();
            run_sum     = SUM_W'(INIT_LEVEL * (WIDTH_DEFAULT >> WIN_SHIFT));
            col_pos     = 0;
            backwards   = 1'b0;
            top_row     = 1'b1;
            expected_pixels.delete();
            pixels_in_flight = 0;
            mismatch_count   = 0;
        end else begin
            // output first: a result can never belong to a pixel taken at this edge
            if (out_valid && !out_stall) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result: white %0b, column %0d",
                             $time, white, column);
                    mismatch_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (white !== want.white) begin
                        $display("%0t: white mismatch: expected %0b, got %0b",
                                 $time, want.white, white);
                        mismatch_count++;
                    end
                    if (column !== want.column) begin
                        $display("%0t: column mismatch: expected %0d, got %0d",
                                 $time, want.column, column);
                        mismatch_count++;
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[REG_SEL_BIT] == REG_LINE_WIDTH)
                    width_reg = pwdata[LINE_WIDTH_W-1:0];
                else
                    percent_reg = pwdata[PERCENT_W-1:0];
                rederive();
            end
            if (in_valid && !in_stall)
                expected_pixels.push_back(threshold_pixel(pixel, frame_start));
            pixels_in_flight = expected_pixels.size();
        end
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import atsu_pkg::*;

    localparam int MAX_COLS = 4096;
    localparam int FRAC     = 9;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    psel          = 1'b0;
    logic                    penable       = 1'b0;
    logic                    pwrite        = 1'b0;
    logic [CFG_ADDR_W-1:0]   paddr         = '0;
    logic [APB_DATA_W-1:0]   pwdata        = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    i_in_valid    = 1'b0;
    logic                    o_in_stall;
    logic [PIXEL_W-1:0]      i_pixel       = '0;
    logic                    i_frame_start = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_stall   = 1'b0;
    logic                    o_white;
    logic [COLUMN_W-1:0]     o_column;

    int mismatch_count;
    int pixels_in_flight;
    int cur_width;
    int random_items;
    int phase_no;
    bit calm;
    bit hold_req;
    bit hold_done;

    always #5 i_clk = ~i_clk;

    adaptive_threshold_serpentine_unit #(
        .MAX_WIDTH (MAX_COLS),
        .FRAC_BITS (FRAC)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_white       (o_white),
        .o_column      (o_column)
    );

    binarise_checker #(
        .MAX_COLS (MAX_COLS),
        .FRAC     (FRAC)
    ) u_checker (
        .clk              (i_clk),
        .rst_n            (i_rst_n),
        .in_valid         (i_in_valid),
        .in_stall         (o_in_stall),
        .pixel            (i_pixel),
        .frame_start      (i_frame_start),
        .out_valid        (o_out_valid),
        .out_stall        (i_out_stall),
        .white            (o_white),
        .column           (o_column),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .mismatch_count   (mismatch_count),
        .pixels_in_flight (pixels_in_flight)
    );

    // mostly short, now and then long
    function automatic int stretch();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 30);
    endfunction

    task automatic send_pixel(input logic [PIXEL_W-1:0] p, input logic fs);
        int gap;
        gap = (calm || $urandom_range(0, 99) < 65) ? 0 : stretch();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pixel       <= p;
        i_frame_start <= fs;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // stop offering, wait for the pipeline to drain, then let the divider and core go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pixels_in_flight != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic sel, input logic [APB_DATA_W-1:0] v);
        logic [CFG_ADDR_W-1:0] a;
        a = '0;
        a[REG_SEL_BIT] = sel;
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // negative w_raw / pct_raw leaves that register alone
    task automatic run_phase(input int w_raw, input int pct_raw, input int n,
                             input bit fs_first, input bit squeeze);
        int ew;
        bit fs;
        bit lead_fs;
        lead_fs = fs_first;
        if (w_raw >= 0) begin
            write_reg(REG_LINE_WIDTH, w_raw);
            ew = (w_raw < WIDTH_MIN) ? WIDTH_MIN : ((w_raw > MAX_COLS) ? MAX_COLS : w_raw);
            // a wider row would read store columns never written: new frame
            if (ew > cur_width) lead_fs = 1'b1;
            cur_width = ew;
        end
        if (pct_raw >= 0) write_reg(REG_PERCENT, pct_raw);
        if (squeeze) hold_req = 1'b1;
        for (int i = 0; i < n; i++) begin
            fs = (i == 0) ? lead_fs : ($urandom_range(0, 79) == 0);
            send_pixel(8'($urandom_range(0, 255)), fs);
        end
    endtask

    // receiver side
    initial begin : out_stall_gen
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
            end else if (calm) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else if ($urandom_range(0, 99) < 55) begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b1;
                repeat (stretch()) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int r;
        int w;
        int pct;
        int n;
        int ew;
        bit squeeze;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        cur_width = WIDTH_DEFAULT;

        // pixel extremes at the reset setting, first row only
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hff, 1'b0);
        send_pixel(8'h80, 1'b0);
        send_pixel(8'h01, 1'b0);
        send_pixel(8'hfe, 1'b0);

        // both registers out of range: narrowest row, steepest percent;
        // two full rows then a partial one, across the serpentine turn
        write_reg(REG_LINE_WIDTH, 3);
        write_reg(REG_PERCENT, 127);
        cur_width = WIDTH_MIN;
        for (int i = 0; i < 20; i++)
            send_pixel((i < 8) ? (i[0] ? 8'hff : 8'h00) : 8'(i * 29), i == 0);

        // oversized width saturates to the full store
        calm = 1'b1;
        run_phase(8191, 0, 40, 1'b1, 1'b0);
        calm = 1'b0;

        random_items = 0;
        phase_no = 0;
        while (random_items < 1100) begin
            r = $urandom_range(0, 99);
            if (r < 60)      w = $urandom_range(8, 40);
            else if (r < 75) w = $urandom_range(41, 700);
            else if (r < 83) w = $urandom_range(0, 7);
            else if (r < 88) w = MAX_COLS;
            else if (r < 93) w = $urandom_range(MAX_COLS + 1, 8191);
            else             w = WIDTH_MIN;
            if ($urandom_range(0, 9) < 3) w = -1;
            r = $urandom_range(0, 99);
            if (r < 70)      pct = $urandom_range(0, PERCENT_MAX);
            else if (r < 80) pct = 0;
            else if (r < 90) pct = PERCENT_MAX;
            else             pct = $urandom_range(PERCENT_MAX + 1, 127);
            if ($urandom_range(0, 9) < 3) pct = -1;
            ew = (w < 0) ? cur_width
                 : ((w < WIDTH_MIN) ? WIDTH_MIN : ((w > MAX_COLS) ? MAX_COLS : w));
            n = (ew <= 64) ? $urandom_range(30, 150) : $urandom_range(10, 60);
            squeeze = (phase_no == 3);
            if (squeeze) begin
                calm = 1'b1;
                n = 120;
            end else begin
                calm = ($urandom_range(0, 4) == 0);
            end
            run_phase(w, pct, n, 1'($urandom_range(0, 1)), squeeze);
            random_items += n;
            phase_no++;
        end
        calm = 1'b0;

        settle();
        if (mismatch_count == 0 && pixels_in_flight == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/atsu_pkg.sv
rtl/core/atsu_div.sv
rtl/core/atsu_cfg.sv
rtl/core/atsu_core.sv
rtl/core/adaptive_threshold_serpentine_unit.sv
test/binarise_checker.sv
test/tb_top.sv
